FILE: rtl/core/cbba_pkg.sv
// ----------------------------------------------------------------------------
// cbba_pkg
// Shared constants and types of the contiguous bitmap block allocator.
// ----------------------------------------------------------------------------
package cbba_pkg;

  localparam int WORD_W  = 64;
  localparam int WORD_AW = 6;
  localparam int RUN_W   = 7;
  localparam int IDX_W   = 10;
  localparam int LIM_W   = 17;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;

  typedef struct packed {
    logic               hit;
    logic [WORD_AW-1:0] pos;
  } fit_res_t;

endpackage

FILE: rtl/core/cbba_map_mem.sv
// ----------------------------------------------------------------------------
// cbba_map_mem
// Used-map storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module cbba_map_mem
  import cbba_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/cbba_fit.sv
// ----------------------------------------------------------------------------
// cbba_fit
// Finds the lowest bit of the current word at which a free run of the
// requested length ends, the run possibly starting in the previous word.
// ----------------------------------------------------------------------------
module cbba_fit
  import cbba_pkg::*;
(
  input  logic [WORD_W-1:0] free_cur_i,
  input  logic [WORD_W-1:0] free_prev_i,
  input  logic [RUN_W-1:0]  len_i,
  output fit_res_t          res_o
);

  logic [2*WORD_W-1:0] ext;
  logic [WORD_W-1:0]   ign;
  logic [WORD_W-1:0]   hit_vec;
  logic [RUN_W-1:0]    keep;

  assign ext  = {free_cur_i, free_prev_i};
  assign keep = RUN_W'(WORD_W) - len_i;
  assign ign  = (WORD_W'(1) << keep[WORD_AW-1:0]) - WORD_W'(1);

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      hit_vec[j] = &(ext[j+1 +: WORD_W] | ign);
    end
  end

  always_comb begin
    res_o.hit = |hit_vec;
    res_o.pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        res_o.pos = WORD_AW'(j);
      end
    end
  end

endmodule

FILE: rtl/core/contiguous_bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_bitmap_block_allocator_top
// First-fit allocator of contiguous block runs over a word-wide used map.
//
// Channel  | Direction | tdata (low bit up)               | tuser   | tlast
// s_axis   | in        | run_length[6:0], block_index[9:0] | cmd     | -
// m_axis   | out       | block_index_res[9:0]             | status  | last
//
// After reset a clearing pass writes zero to every word of the map in turn; no
// request is taken during it. A free request of a block in range clears the
// block's bit in its map word; every free request then replies. An allocate
// request scans the map one 64-block word at a time, writes the marked words
// back (the current word, then the previous word when the run starts there),
// then emits one result per allocated block.
// A stall on m_axis holds the sequencer; one request is in work at a time.
// ----------------------------------------------------------------------------
module contiguous_bitmap_block_allocator_top
  import cbba_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024,
  parameter int MAX_RUN    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // run_length[6:0], block_index[16:7], zero fill
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // block_index_res[9:0], zero fill
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IW        = WA + WORD_AW;
  localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
  localparam logic [WA-1:0]     LAST_WORD = WA'(NUM_WORDS - 1);
  localparam logic [RUN_W-1:0]  MAX_LEN   = RUN_W'(MAX_RUN);
  localparam logic [LIM_W-1:0]  BLK_LIMIT = LIM_W'(NUM_BLOCKS);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_FREE_RD   = 7'b0000100,
    S_SCAN      = 7'b0001000,
    S_MARK      = 7'b0010000,
    S_MARK_PREV = 7'b0100000,
    S_REPLY     = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic              emit_q, emit_d;
  logic [WA-1:0]     word_q, word_d;
  logic [RUN_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  logic [WORD_W-1:0]  prev_data_q, prev_data_d;
  logic [WORD_W-1:0]  cur_data_q, cur_data_d;
  logic [WORD_AW-1:0] pos_q, pos_d;
  logic [RUN_W-1:0]   len_q, len_d;
  logic [IDX_W-1:0]   blk_q, blk_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [1:0]         reply_status_q, reply_status_d;
  logic [IDX_W-1:0]   reply_idx_q, reply_idx_d;
  logic [1:0]         out_status_q, out_status_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic               out_last_q, out_last_d;

  logic              in_cmd;
  logic [RUN_W-1:0]  in_len;
  logic [IDX_W-1:0]  in_blk;
  logic              in_acc;
  logic              out_free;
  logic              blk_ok;

  logic              mem_we;
  logic [WA-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WA-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic [WORD_W-1:0]   free_cur;
  logic [WORD_W-1:0]   free_prev;
  fit_res_t            fit;
  logic [RUN_W-1:0]    mark_sh;
  logic [2*WORD_W-1:0] mark_mask;
  logic [IW-1:0]       run_start;

  assign in_cmd = s_axis_tuser;
  assign in_len = s_axis_tdata[RUN_W-1:0];
  assign in_blk = s_axis_tdata[RUN_W +: IDX_W];

  assign s_axis_tready = (state_q == S_IDLE) && !emit_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign blk_ok        = LIM_W'(in_blk) < BLK_LIMIT;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 16'(out_idx_q);
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  assign free_cur  = ~mem_rdata & ((word_q == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}});
  assign free_prev = (word_q == '0) ? '0 : ~prev_data_q;

  cbba_fit u_fit (
    .free_cur_i  (free_cur),
    .free_prev_i (free_prev),
    .len_i       (len_q),
    .res_o       (fit)
  );

  assign mark_sh   = RUN_W'(8'(pos_q) + 8'(WORD_W + 1) - 8'(len_q));
  assign mark_mask = (((2*WORD_W)'(1) << len_q) - (2*WORD_W)'(1)) << mark_sh;
  assign run_start = IW'({word_q, pos_q}) + IW'(1) - IW'(len_q);

  cbba_map_mem #(
    .DEPTH (NUM_WORDS),
    .AW    (WA)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d        = state_q;
    emit_d         = emit_q;
    word_d         = word_q;
    cnt_d          = cnt_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    prev_data_d    = prev_data_q;
    cur_data_d     = cur_data_q;
    pos_d          = pos_q;
    len_d          = len_q;
    blk_d          = blk_q;
    idx_d          = idx_q;
    reply_status_d = reply_status_q;
    reply_idx_d    = reply_idx_q;
    out_status_d   = out_status_q;
    out_idx_d      = out_idx_q;
    out_last_d     = out_last_q;
    mem_we         = 1'b0;
    mem_waddr      = word_q;
    mem_wdata      = '0;
    mem_raddr      = word_q + WA'(1);

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        word_d = word_q + WA'(1);
        if (word_q == LAST_WORD) begin
          word_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (emit_q) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_ALLOC;
            out_idx_d    = IDX_W'(idx_q);
            out_last_d   = (cnt_q == RUN_W'(1));
            idx_d        = idx_q + IW'(1);
            cnt_d        = cnt_q - RUN_W'(1);
            emit_d       = (cnt_q != RUN_W'(1));
          end
        end else begin
          mem_raddr = (in_cmd == CMD_FREE) ? WA'(in_blk >> WORD_AW) : '0;
          if (in_acc) begin
            blk_d  = in_blk;
            len_d  = in_len;
            word_d = '0;
            if (in_cmd == CMD_FREE) begin
              reply_status_d = ST_FREED;
              reply_idx_d    = in_blk;
              state_d        = blk_ok ? S_FREE_RD : S_REPLY;
            end else if ((in_len == '0) || (in_len > MAX_LEN)) begin
              reply_status_d = ST_NOSPACE;
              reply_idx_d    = '0;
              state_d        = S_REPLY;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_FREE_RD: begin
        mem_we    = 1'b1;
        mem_waddr = WA'(blk_q >> WORD_AW);
        mem_wdata = mem_rdata & ~(WORD_W'(1) << blk_q[WORD_AW-1:0]);
        state_d   = S_REPLY;
      end
      S_SCAN: begin
        if (fit.hit) begin
          cur_data_d = mem_rdata;
          pos_d      = fit.pos;
          state_d    = S_MARK;
        end else if (word_q == LAST_WORD) begin
          reply_status_d = ST_NOSPACE;
          reply_idx_d    = '0;
          state_d        = S_REPLY;
        end else begin
          prev_data_d = mem_rdata;
          word_d      = word_q + WA'(1);
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = cur_data_q | mark_mask[2*WORD_W-1:WORD_W];
        idx_d     = run_start;
        cnt_d     = len_q;
        if (|mark_mask[WORD_W-1:0]) begin
          state_d = S_MARK_PREV;
        end else begin
          emit_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MARK_PREV: begin
        mem_we    = 1'b1;
        mem_waddr = word_q - WA'(1);
        mem_wdata = prev_data_q | mark_mask[WORD_W-1:0];
        emit_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_REPLY: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = reply_status_q;
          out_idx_d    = reply_idx_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      emit_q      <= 1'b0;
      word_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      word_q      <= word_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_data_q    <= prev_data_d;
    cur_data_q     <= cur_data_d;
    pos_q          <= pos_d;
    len_q          <= len_d;
    blk_q          <= blk_d;
    idx_q          <= idx_d;
    reply_status_q <= reply_status_d;
    reply_idx_q    <= reply_idx_d;
    out_status_q   <= out_status_d;
    out_idx_q      <= out_idx_d;
    out_last_q     <= out_last_d;
  end

  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mem_we)
    else $error("map written while a new transaction can be taken");

  a_single_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_ALLOC)) |-> m_axis_tlast)
    else $error("single-result transaction without last");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> (cnt_q != '0))
    else $error("result emission with no blocks left");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && !fit.hit && (word_q == LAST_WORD)) |=> (state_q == S_REPLY))
    else $error("scan past the last word did not report no space");

  a_alloc_consecutive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_q && out_free && (cnt_q != RUN_W'(1))) |=> (idx_q == $past(idx_q) + IW'(1)))
    else $error("allocated block numbers not consecutive");

  a_mark_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> (state_d == S_MARK_PREV || state_d == S_IDLE))
    else $error("unexpected state after marking");

endmodule
